@@ sv/oaht_pkg.sv @@
// Types and codes shared by the open-address hash table and its test bench.
// No dependencies.
`default_nettype none
package oaht_pkg;

  typedef enum logic [1:0] {
    CMD_GET = 2'd0,
    CMD_SET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MOD, S_PRD, S_PCHK, S_FIN,
    S_MCLR, S_MRD, S_MCHK, S_MPRD, S_MPCHK
  } state_t;

  localparam int LimitW = 10;
  localparam int LiveW  = 11;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [31:0] key_hash;
    logic [63:0] write_value;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             is_new;
    logic [63:0]      read_value;
    logic [LiveW-1:0] live_entries;
  } result_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] hash;
    logic [63:0] value;
  } slot_t;

endpackage
`default_nettype wire

@@ sv/open_address_hash_table.sv @@
// Open-address hash table with linear probing, tombstones and bank moves.
// Depends on oaht_pkg and oaht_ram.
//
// Usage: drive an item on 'item' and raise start; it is taken at a rising
// edge with start high and busy low. The result appears on 'result' with
// done high for exactly one cycle; the receiver cannot stall it. load_limit
// is written through cfg_we/cfg_data, only while the block is idle; the user
// keeps to this, the block itself does not enforce it.
// Sequence: hash reduction (by reciprocal multiply when CAPACITY is not a
// power of two), then a first read issue and a probe of slots over the
// single read port of the slot RAMs, then a write-back; the result follows in the next cycle.
// A set that triggers a bank move first clears the target marks and scans
// the source slots; each live entry then adds the hash reduction, a read
// issue and a probe of target slots until an empty one is found.
// Reset starts a clearing pass over all 2*CAPACITY slot marks, one per
// cycle; busy stays high during the pass. Configuration writes are taken
// at any time.
`default_nettype none
module open_address_hash_table #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire oaht_pkg::item_t              item,
  output logic                              done,
  output oaht_pkg::result_t                 result,
  input  wire logic                         cfg_we,
  input  wire logic [oaht_pkg::LimitW-1:0]  cfg_data
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int AW   = $clog2(2 * CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > oaht_pkg::LimitW) ? CW : oaht_pkg::LimitW;
  localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam logic [AW-1:0] CapA   = AW'(CAPACITY);
  localparam logic [IW-1:0] LastI  = IW'(CAPACITY - 1);
  localparam logic [AW-1:0] LastA  = AW'(2 * CAPACITY - 1);
  // rounded-up reciprocal, exact quotient of any 32-bit hash by CAPACITY
  localparam logic [63:0] Recip =
    ((64'd1 << (32 + IW)) + 64'(CAPACITY - 1)) / 64'(CAPACITY);

  // control registers
  oaht_pkg::state_t state, state_next;
  logic [oaht_pkg::LimitW-1:0] load_limit;
  logic          bank;
  logic [CW-1:0] live, used;
  logic [AW-1:0] clr_addr;
  logic          in_move, refuse, hit, room_ok, room_empty, tomb_ok;
  logic [1:0]    mod_cnt;

  // payload registers
  oaht_pkg::item_t req;
  oaht_pkg::slot_t mv_slot;
  logic [31:0]   mod_src;
  logic [48:0]   prod_lo;
  logic [47:0]   prod_hi;
  logic [31:0]   quo;
  logic [IW-1:0] cur, cnt, src_i, room, tomb, hit_idx;
  logic [63:0]   hit_value;

  // memory ports
  logic          mark_we, data_we;
  logic [AW-1:0] raddr, waddr;
  logic [1:0]    mark_wdata, mark_rdata;
  oaht_pkg::slot_t data_wdata, data_rdata;

  function automatic logic [AW-1:0] slot_addr(input logic b, input logic [IW-1:0] i);
    slot_addr = b ? (CapA + AW'(i)) : AW'(i);
  endfunction

  function automatic logic [IW-1:0] step(input logic [IW-1:0] i);
    step = (i == LastI) ? '0 : i + IW'(1);
  endfunction

  oaht_ram #(.WIDTH(2), .DEPTH(2 * CAPACITY)) u_mark (
    .clk(clk), .we(mark_we), .waddr(waddr), .wdata(mark_wdata),
    .raddr(raddr), .rdata(mark_rdata)
  );

  oaht_ram #(.WIDTH($bits(oaht_pkg::slot_t)), .DEPTH(2 * CAPACITY)) u_data (
    .clk(clk), .we(data_we), .waddr(waddr), .wdata(data_wdata),
    .raddr(raddr), .rdata(data_rdata)
  );

  // probe decode of the slot just read
  logic p_empty, p_match, p_tomb, p_last;
  logic at_limit, live_at_limit;
  assign p_empty = (oaht_pkg::mark_t'(mark_rdata) == oaht_pkg::MARK_EMPTY);
  assign p_match = (oaht_pkg::mark_t'(mark_rdata) == oaht_pkg::MARK_LIVE) &&
                   (data_rdata.key == req.key);
  assign p_tomb  = (oaht_pkg::mark_t'(mark_rdata) == oaht_pkg::MARK_TOMB);
  assign p_last  = (cnt == LastI);
  assign at_limit      = CMPW'(used) >= CMPW'(load_limit);
  assign live_at_limit = CMPW'(live) >= CMPW'(load_limit);

  assign busy = (state != oaht_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oaht_pkg::S_CLR:  if (clr_addr == LastA) state_next = oaht_pkg::S_IDLE;
      oaht_pkg::S_IDLE: begin
        if (start) begin
          unique case (oaht_pkg::cmd_t'(item.cmd))
            oaht_pkg::CMD_NOP: state_next = oaht_pkg::S_FIN;
            oaht_pkg::CMD_SET: state_next = (at_limit && !live_at_limit) ?
                                            oaht_pkg::S_MCLR : oaht_pkg::S_MOD;
            default:           state_next = oaht_pkg::S_MOD;
          endcase
        end
      end
      oaht_pkg::S_MOD: begin
        if (POW2 || mod_cnt == 2'd2) begin
          state_next = in_move ? oaht_pkg::S_MPRD : oaht_pkg::S_PRD;
        end
      end
      oaht_pkg::S_PRD:  state_next = oaht_pkg::S_PCHK;
      oaht_pkg::S_PCHK: if (p_empty || p_match || p_last) state_next = oaht_pkg::S_FIN;
      oaht_pkg::S_FIN:  state_next = oaht_pkg::S_IDLE;
      oaht_pkg::S_MCLR: if (cur == LastI) state_next = oaht_pkg::S_MRD;
      oaht_pkg::S_MRD:  state_next = oaht_pkg::S_MCHK;
      oaht_pkg::S_MCHK: begin
        if (oaht_pkg::mark_t'(mark_rdata) == oaht_pkg::MARK_LIVE) begin
          state_next = oaht_pkg::S_MOD;
        end else begin
          state_next = (src_i == LastI) ? oaht_pkg::S_MOD : oaht_pkg::S_MRD;
        end
      end
      oaht_pkg::S_MPRD:  state_next = oaht_pkg::S_MPCHK;
      oaht_pkg::S_MPCHK: begin
        if (p_empty) begin
          state_next = (src_i == LastI) ? oaht_pkg::S_MOD : oaht_pkg::S_MRD;
        end
      end
      default: state_next = oaht_pkg::S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    mark_we    = 1'b0;
    data_we    = 1'b0;
    waddr      = slot_addr(bank, cur);
    mark_wdata = oaht_pkg::MARK_EMPTY;
    data_wdata = mv_slot;
    raddr      = slot_addr(bank, cur);
    unique case (state)
      oaht_pkg::S_CLR: begin
        mark_we = 1'b1;
        waddr   = clr_addr;
      end
      oaht_pkg::S_PCHK: raddr = slot_addr(bank, step(cur));
      oaht_pkg::S_FIN: begin
        data_wdata = '{key: req.key, hash: req.key_hash, value: req.write_value};
        if (oaht_pkg::cmd_t'(req.cmd) == oaht_pkg::CMD_SET) begin
          if (hit) begin
            data_we = 1'b1;
            waddr   = slot_addr(bank, hit_idx);
          end else if (!refuse && room_ok) begin
            data_we    = 1'b1;
            mark_we    = 1'b1;
            mark_wdata = oaht_pkg::MARK_LIVE;
            waddr      = slot_addr(bank, room);
          end
        end else if (oaht_pkg::cmd_t'(req.cmd) == oaht_pkg::CMD_DEL && hit) begin
          mark_we    = 1'b1;
          mark_wdata = oaht_pkg::MARK_TOMB;
          waddr      = slot_addr(bank, hit_idx);
        end
      end
      oaht_pkg::S_MCLR: begin
        mark_we = 1'b1;
        waddr   = slot_addr(!bank, cur);
      end
      oaht_pkg::S_MRD: raddr = slot_addr(bank, src_i);
      oaht_pkg::S_MPRD: raddr = slot_addr(!bank, cur);
      oaht_pkg::S_MPCHK: begin
        raddr      = slot_addr(!bank, step(cur));
        waddr      = slot_addr(!bank, cur);
        mark_wdata = oaht_pkg::MARK_LIVE;
        mark_we    = p_empty;
        data_we    = p_empty;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= oaht_pkg::S_CLR;
      load_limit <= oaht_pkg::LimitW'(768);
      bank       <= 1'b0;
      live       <= '0;
      used       <= '0;
      clr_addr   <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == oaht_pkg::S_FIN);
      if (cfg_we) begin
        load_limit <= cfg_data;
      end
      if (state == oaht_pkg::S_CLR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      // switch banks once the last source slot is handled
      if ((state == oaht_pkg::S_MCHK && state_next == oaht_pkg::S_MOD && !in_move &&
           oaht_pkg::mark_t'(mark_rdata) != oaht_pkg::MARK_LIVE) ||
          (state == oaht_pkg::S_MPCHK && p_empty && src_i == LastI)) begin
        bank <= !bank;
        used <= live;
      end
      if (state == oaht_pkg::S_FIN) begin
        if (oaht_pkg::cmd_t'(req.cmd) == oaht_pkg::CMD_SET && !hit && !refuse && room_ok) begin
          live <= live + CW'(1);
          if (room_empty) used <= used + CW'(1);
        end else if (oaht_pkg::cmd_t'(req.cmd) == oaht_pkg::CMD_DEL && hit) begin
          live <= live - CW'(1);
        end
      end
    end
  end

  // result of the item in hand, registered in S_FIN
  oaht_pkg::result_t fin_res;
  always_comb begin
    fin_res.status       = oaht_pkg::ST_DONE;
    fin_res.is_new       = 1'b0;
    fin_res.read_value   = '0;
    fin_res.live_entries = oaht_pkg::LiveW'(live);
    unique case (oaht_pkg::cmd_t'(req.cmd))
      oaht_pkg::CMD_GET: begin
        if (hit) fin_res.read_value = hit_value;
        else     fin_res.status     = oaht_pkg::ST_ABSENT;
      end
      oaht_pkg::CMD_SET: begin
        if (!hit && (refuse || !room_ok)) begin
          fin_res.status = oaht_pkg::ST_FULL;
        end else if (!hit) begin
          fin_res.is_new       = 1'b1;
          fin_res.live_entries = oaht_pkg::LiveW'(live + CW'(1));
        end
      end
      oaht_pkg::CMD_DEL: begin
        if (hit) fin_res.live_entries = oaht_pkg::LiveW'(live - CW'(1));
        else     fin_res.status       = oaht_pkg::ST_ABSENT;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      oaht_pkg::S_IDLE: begin
        req        <= item;
        mod_src    <= item.key_hash;
        mod_cnt    <= '0;
        cur        <= '0;
        in_move    <= 1'b0;
        hit        <= 1'b0;
        room_ok    <= 1'b0;
        room_empty <= 1'b0;
        tomb_ok    <= 1'b0;
        src_i      <= '0;
        refuse     <= at_limit && live_at_limit;
      end
      oaht_pkg::S_MOD: begin
        if (POW2) begin
          cur <= mod_src[IW-1:0];
        end else begin
          // reduce by reciprocal multiply: partial products, quotient, remainder
          unique case (mod_cnt)
            2'd0: begin
              prod_lo <= 49'(mod_src) * 49'(Recip[16:0]);
              prod_hi <= 48'(mod_src) * 48'(Recip[32:17]);
            end
            2'd1: quo <= 32'(({prod_hi, 17'd0} + 65'(prod_lo)) >> (32 + IW));
            2'd2: cur <= IW'(mod_src - quo * 32'(CAPACITY));
            default: ;
          endcase
          mod_cnt <= mod_cnt + 2'd1;
        end
        cnt     <= '0;
        tomb_ok <= 1'b0;
      end
      oaht_pkg::S_PCHK: begin
        cnt <= cnt + IW'(1);
        cur <= step(cur);
        if (p_match) begin
          hit       <= 1'b1;
          hit_idx   <= cur;
          hit_value <= data_rdata.value;
        end else if (p_empty) begin
          room_ok    <= 1'b1;
          room       <= tomb_ok ? tomb : cur;
          room_empty <= !tomb_ok;
        end else if (p_tomb && !tomb_ok) begin
          tomb_ok <= 1'b1;
          tomb    <= cur;
          if (p_last) begin
            room_ok <= 1'b1;
            room    <= cur;
          end
        end else if (p_last) begin
          room_ok <= tomb_ok;
          room    <= tomb;
        end
      end
      oaht_pkg::S_FIN: begin
        result <= fin_res;
      end
      oaht_pkg::S_MCLR: begin
        cur <= step(cur);
      end
      oaht_pkg::S_MCHK: begin
        mod_cnt <= '0;
        cur     <= '0;
        if (oaht_pkg::mark_t'(mark_rdata) == oaht_pkg::MARK_LIVE) begin
          mv_slot <= data_rdata;
          mod_src <= data_rdata.hash;
          in_move <= 1'b1;
        end else if (src_i == LastI) begin
          mod_src <= req.key_hash;
        end else begin
          src_i <= src_i + IW'(1);
        end
      end
      oaht_pkg::S_MPCHK: begin
        if (p_empty) begin
          cur     <= '0;
          mod_cnt <= '0;
          in_move <= 1'b0;
          if (src_i == LastI) begin
            mod_src <= req.key_hash;
          end else begin
            src_i <= src_i + IW'(1);
          end
        end else begin
          cur <= step(cur);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/oaht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ verif/open_address_hash_table_test.sv @@
// Self-checking test of open_address_hash_table: directed table, then random items.
// Holds its own table predictor; depends on oaht_pkg and the block's RTL.
`default_nettype none
module open_address_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  oaht_pkg::item_t item = '0;
  logic done;
  oaht_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [oaht_pkg::LimitW-1:0] cfg_data = '0;

  open_address_hash_table #(.CAPACITY(Cap)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: two banks of slots
  logic [63:0] tbl_key [2*Cap];
  logic [31:0] tbl_hash [2*Cap];
  logic [63:0] tbl_val [2*Cap];
  oaht_pkg::mark_t tbl_mark [2*Cap];
  bit bank;
  int unsigned live_n, used_n, limit_v;

  oaht_pkg::result_t pending_q[$];
  int errors = 0;
  int sender_idle = 0;

  // Probe the active bank for key; return live hit and free slot (or -1)
  function automatic void find_slot(input logic [63:0] k, input logic [31:0] h,
                                    output int hit, output int room);
    int base, idx, tomb, s;
    base = bank ? Cap : 0;
    idx = h % Cap;
    tomb = -1;
    hit = -1;
    room = -1;
    for (int n = 0; n < Cap; n++) begin
      s = base + idx;
      if (tbl_mark[s] == oaht_pkg::MARK_EMPTY) begin
        room = (tomb >= 0) ? tomb : s;
        return;
      end
      if (tbl_mark[s] == oaht_pkg::MARK_LIVE) begin
        if (tbl_key[s] == k) begin
          hit = s;
          return;
        end
      end else if (tomb < 0) begin
        tomb = s;
      end
      idx = (idx + 1) % Cap;
    end
    room = tomb;
  endfunction

  // Rehash live entries into the other bank and switch to it
  function automatic void swap_bank();
    int src, dst, idx, d;
    src = bank ? Cap : 0;
    dst = bank ? 0 : Cap;
    for (int i = 0; i < Cap; i++) tbl_mark[dst+i] = oaht_pkg::MARK_EMPTY;
    for (int i = 0; i < Cap; i++) begin
      if (tbl_mark[src+i] != oaht_pkg::MARK_LIVE) continue;
      idx = tbl_hash[src+i] % Cap;
      for (int n = 0; n < Cap; n++) begin
        d = dst + idx;
        if (tbl_mark[d] == oaht_pkg::MARK_EMPTY) begin
          tbl_mark[d] = oaht_pkg::MARK_LIVE;
          tbl_key[d] = tbl_key[src+i];
          tbl_hash[d] = tbl_hash[src+i];
          tbl_val[d] = tbl_val[src+i];
          break;
        end
        idx = (idx + 1) % Cap;
      end
    end
    bank = ~bank;
    used_n = live_n;
  endfunction

  function automatic oaht_pkg::result_t predict_table(input oaht_pkg::item_t it);
    oaht_pkg::result_t r;
    int hit, room;
    bit refuse;
    r = '0;
    refuse = 0;
    case (oaht_pkg::cmd_t'(it.cmd))
      oaht_pkg::CMD_GET: begin
        find_slot(it.key, it.key_hash, hit, room);
        if (hit >= 0) r.read_value = tbl_val[hit];
        else r.status = oaht_pkg::ST_ABSENT;
      end
      oaht_pkg::CMD_SET: begin
        if (used_n + 1 > limit_v) begin
          if (live_n + 1 > limit_v) refuse = 1;
          else swap_bank();
        end
        find_slot(it.key, it.key_hash, hit, room);
        if (hit >= 0) begin
          tbl_val[hit] = it.write_value;
          tbl_hash[hit] = it.key_hash;
        end else if (refuse || room < 0) begin
          r.status = oaht_pkg::ST_FULL;
        end else begin
          if (tbl_mark[room] == oaht_pkg::MARK_EMPTY) used_n++;
          live_n++;
          tbl_mark[room] = oaht_pkg::MARK_LIVE;
          tbl_key[room] = it.key;
          tbl_hash[room] = it.key_hash;
          tbl_val[room] = it.write_value;
          r.is_new = 1'b1;
        end
      end
      oaht_pkg::CMD_DEL: begin
        find_slot(it.key, it.key_hash, hit, room);
        if (hit >= 0) begin
          tbl_mark[hit] = oaht_pkg::MARK_TOMB;
          live_n--;
        end else begin
          r.status = oaht_pkg::ST_ABSENT;
        end
      end
      default: ;
    endcase
    r.live_entries = live_n[oaht_pkg::LiveW-1:0];
    return r;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, result);
        errors++;
      end else begin
        oaht_pkg::result_t e;
        e = pending_q.pop_front();
        if (result.status !== e.status || result.is_new !== e.is_new ||
            result.read_value !== e.read_value ||
            result.live_entries !== e.live_entries) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, e, result);
          errors++;
        end
      end
    end
  end

  // Issue one item; a typed expectation overrides the predictor when given
  task automatic issue(input oaht_pkg::item_t it, input bit typed,
                       input oaht_pkg::result_t want);
    oaht_pkg::result_t p;
    @(negedge clk);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) @(negedge clk);
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_table(it);
    pending_q.push_back(typed ? want : p);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Quiesce, then write load_limit in both the block and the predictor
  task automatic set_limit(input int unsigned v);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (3 * Cap + 200) @(negedge clk);
    cfg_data <= v[oaht_pkg::LimitW-1:0];
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_v = v;
  endtask

  function automatic oaht_pkg::item_t mk(input oaht_pkg::cmd_t c, input logic [63:0] k,
                                         input logic [31:0] h, input logic [63:0] v);
    oaht_pkg::item_t it;
    it.cmd = c;
    it.key = k;
    it.key_hash = h;
    it.write_value = v;
    return it;
  endfunction

  function automatic oaht_pkg::result_t rs(input oaht_pkg::status_t s, input bit n,
                                           input logic [63:0] v, input int l);
    oaht_pkg::result_t r;
    r.status = s;
    r.is_new = n;
    r.read_value = v;
    r.live_entries = l[oaht_pkg::LiveW-1:0];
    return r;
  endfunction

  typedef struct {
    oaht_pkg::item_t it;
    bit typed;
    oaht_pkg::result_t want;
  } step_row_t;

  step_row_t dir_rows[$];
  logic [63:0] key_pool[16];
  logic [31:0] hash_pool[16];

  initial begin
    oaht_pkg::item_t it;
    int pi, phase;
    for (int i = 0; i < 2*Cap; i++) tbl_mark[i] = oaht_pkg::MARK_EMPTY;
    bank = 0;
    live_n = 0;
    used_n = 0;
    limit_v = 768;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every command, tombstone reuse, no-op command
    dir_rows.push_back('{mk(oaht_pkg::CMD_GET, 64'd5, 32'd5, '1), 1,
                         rs(oaht_pkg::ST_ABSENT, 0, 64'd0, 0)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_DEL, '1, '1, '0), 1,
                         rs(oaht_pkg::ST_ABSENT, 0, 64'd0, 0)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_NOP, '1, '1, '1), 1,
                         rs(oaht_pkg::ST_DONE, 0, 64'd0, 0)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_SET, '1, '1, '1), 1,
                         rs(oaht_pkg::ST_DONE, 1, 64'd0, 1)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_SET, '0, '0, '0), 1,
                         rs(oaht_pkg::ST_DONE, 1, 64'd0, 2)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_GET, '1, '1, '0), 1,
                         rs(oaht_pkg::ST_DONE, 0, '1, 2)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_GET, '0, '0, '1), 1,
                         rs(oaht_pkg::ST_DONE, 0, 64'd0, 2)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_SET, '1, '1, 64'h1234), 1,
                         rs(oaht_pkg::ST_DONE, 0, 64'd0, 2)});
    dir_rows.push_back('{mk(oaht_pkg::CMD_SET, 64'd1024, 32'd0, 64'd7), 0, '0});
    dir_rows.push_back('{mk(oaht_pkg::CMD_DEL, '0, '0, '0), 0, '0});
    dir_rows.push_back('{mk(oaht_pkg::CMD_GET, 64'd1024, 32'd0, 64'd0), 0, '0});
    dir_rows.push_back('{mk(oaht_pkg::CMD_SET, 64'd2048, 32'd1024, 64'd9), 0, '0});
    dir_rows.push_back('{mk(oaht_pkg::CMD_GET, 64'd2048, 32'd0, 64'd0), 0, '0});
    dir_rows.push_back('{mk(oaht_pkg::CMD_GET, 64'd2048, 32'd5, 64'd0), 0, '0});
    dir_rows.push_back('{mk(oaht_pkg::CMD_DEL, '1, '1, '0), 0, '0});
    dir_rows.push_back('{mk(oaht_pkg::CMD_NOP, 64'd2048, 32'd0, '1), 0, '0});
    foreach (dir_rows[i]) issue(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Small limits force bank moves and live-limit refusals
    set_limit(1);
    for (int i = 0; i < 8; i++)
      issue(mk(oaht_pkg::cmd_t'($urandom_range(2)), 64'($urandom_range(3)),
               32'($urandom_range(3)), {$urandom, $urandom}), 0, '0);
    set_limit(1023);

    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      hash_pool[i] = $urandom;
    end
    for (int k = 0; k < 1900; k++) begin
      phase = k / 240;
      if (k % 240 == 0) begin
        sender_idle = (phase % 4 == 1) ? 51 : (phase % 4 == 3) ? 28 : 0;
        case (phase)
          2: set_limit(6);
          3: set_limit(40);
          5: set_limit(3);
          6: set_limit(768);
          7: set_limit(12);
          default: ;
        endcase
      end
      pi = $urandom_range(15);
      it.cmd = ($urandom_range(99) < 2) ? oaht_pkg::CMD_NOP :
               oaht_pkg::cmd_t'($urandom_range(2));
      if ($urandom_range(99) < 75) begin
        it.key = key_pool[pi];
        // occasionally give a clashing hash, mostly the key's own
        it.key_hash = ($urandom_range(19) == 0) ? $urandom : hash_pool[pi];
      end else begin
        it.key = {$urandom, $urandom};
        it.key_hash = $urandom;
      end
      // keep low hash bits bunched so probes collide and wrap
      if ($urandom_range(1)) it.key_hash[9:0] = 10'h3F8 + 10'($urandom_range(15));
      it.write_value = {$urandom, $urandom};
      if ($urandom_range(199) == 0) key_pool[pi] = {$urandom, $urandom};
      issue(it, 0, '0);
    end

    while (pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) $display("open_address_hash_table test passed");
    else $display("open_address_hash_table test failed");
    $finish;
  end

  initial begin
    #500ms;
    $display("open_address_hash_table test failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ open_address_hash_table.f @@
sv/oaht_pkg.sv
sv/oaht_ram.sv
sv/open_address_hash_table.sv
verif/open_address_hash_table_test.sv
